// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clock, reset, ante, cons, msg)
`define ASSERT_NEXT(label, clock, reset, ante, cons, msg)

`endif

`endif

// ----- rtl/pru_pkg.sv -----
`timescale 1ns / 1ps
package pru_pkg;

  localparam int PIX_W          = 16;
  localparam int CFG_DIM_W      = 11;
  localparam int CFG_FAC_W      = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_FACTOR = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_WIDTH_FACTOR  = 2'd2,
    REG_HEIGHT_FACTOR = 2'd3
  } cfg_reg_e;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // One pending run of output copies.
  typedef struct packed {
    logic             from_store;
    logic             rejected;
    logic             row_end;
    logic             frame_end;
    logic [PIX_W-1:0] pixel;
  } job_t;

endpackage

// ----- rtl/pru_ifs.sv -----
`timescale 1ns / 1ps
interface pru_cfg_if import pru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DIM_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface pru_in_if import pru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, req_type, pixel_in, input ready);
  modport sink (input valid, req_type, pixel_in, output ready);
endinterface

interface pru_out_if import pru_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             last_of_run;
  logic             row_end;
  logic             frame_end;
  logic             rejected;

  modport source (output valid, pixel_out, last_of_run, row_end, frame_end, rejected,
                  input ready);
  modport sink (input valid, pixel_out, last_of_run, row_end, frame_end, rejected,
                output ready);
endinterface

// ----- rtl/pru_line_store.sv -----
`timescale 1ns / 1ps
module pru_line_store import pru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAX_WIDTH)-1:0] waddr,
  input  logic [PIX_W-1:0]             wdata,
  input  logic                         re,
  input  logic [$clog2(MAX_WIDTH)-1:0] raddr,
  output logic [PIX_W-1:0]             rdata
);

  logic [PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/pru_run_out.sv -----
`timescale 1ns / 1ps
module pru_run_out import pru_pkg::*; #(
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_valid,
  input  job_t                          job,
  input  logic [PIX_W-1:0]              store_rdata,
  input  logic [$clog2(MAX_FACTOR)-1:0] run_len_m1,
  output logic                          job_take,
  pru_out_if.source                     out
);

  localparam int CPY_W = $clog2(MAX_FACTOR);

  logic             run_active;
  logic [CPY_W-1:0] run_left;
  logic [PIX_W-1:0] run_pix;
  logic             run_row_end;
  logic             run_frame_end;
  logic             run_rej;
  logic             out_fire;
  logic             run_last;

  assign out_fire = out.valid && out.ready;
  assign run_last = (run_left == '0);
  // Load the next run when idle or when the last copy leaves.
  assign job_take = job_valid && (!run_active || (out_fire && run_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
    end else if (job_take) begin
      run_active <= 1'b1;
    end else if (out_fire && run_last) begin
      run_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      run_pix       <= job.from_store ? store_rdata : job.pixel;
      run_left      <= job.rejected ? '0 : run_len_m1;
      run_row_end   <= job.row_end;
      run_frame_end <= job.frame_end;
      run_rej       <= job.rejected;
    end else if (out_fire && !run_last) begin
      run_left <= run_left - CPY_W'(1);
    end
  end

  assign out.valid       = run_active;
  assign out.pixel_out   = run_pix;
  assign out.last_of_run = run_last;
  assign out.row_end     = run_last && run_row_end;
  assign out.frame_end   = run_last && run_frame_end;
  assign out.rejected    = run_rej;

endmodule

// ----- rtl/pixel_replication_upscaler.sv -----
// Nearest-neighbor integer upscaler by pixel replication.
// cfg: register writes (index, data), always ready; write only while idle.
//   0 image_width, 1 image_height, 2 width_factor, 3 height_factor.
// pix_in: req_type 0 carries a pixel of the current row (row-major); req_type 1
//   is a replay tick that plays back the next stored pixel of the row.
// pix_out: one beat per output pixel with last_of_run, row_end, frame_end and
//   rejected flags. A pixel sent while a replay is pending gives one rejected beat.
// Each accepted item yields width_factor beats (one for a rejection, none for
// a tick with no replay pending). An item passes the job register, then the
// run register, before its first beat. The output copy counter sets the rate;
// an item is taken each cycle while width_factor is 1 and the output is ready.
// The row is held in a single-port-write, registered-read line store of
// MAX_WIDTH entries; a replay read is always issued after the write it needs.
// A stalled receiver holds the current beat; one further item is buffered and
// the input then stalls. Reset clears position counters and sets all
// configuration registers to 1; the line store is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pixel_replication_upscaler import pru_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic      clk,
  input  logic      rst,
  pru_cfg_if.sink   cfg,
  pru_in_if.sink    pix_in,
  pru_out_if.source pix_out
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int DIM_W = ($clog2(MAX_WIDTH + 1) > CFG_DIM_W) ?
                         $clog2(MAX_WIDTH + 1) : CFG_DIM_W;
  localparam int CPY_W = $clog2(MAX_FACTOR);
  localparam int FAC_W = ($clog2(MAX_FACTOR + 1) > CFG_FAC_W) ?
                         $clog2(MAX_FACTOR + 1) : CFG_FAC_W;

  logic [CFG_DIM_W-1:0] image_width;
  logic [CFG_DIM_W-1:0] image_height;
  logic [CFG_FAC_W-1:0] width_factor;
  logic [CFG_FAC_W-1:0] height_factor;

  logic [COL_W-1:0] in_column, in_column_next;
  logic [COL_W-1:0] in_row, in_row_next;
  logic [CPY_W-1:0] replay_copy, replay_copy_next;
  logic [COL_W-1:0] replay_column, replay_column_next;
  logic             replay_pending, replay_pending_next;

  logic             job_valid;
  job_t             job;
  job_t             job_new;
  logic             new_job;
  logic             job_take;

  logic             st_we;
  logic             st_re;
  logic [PIX_W-1:0] st_rdata;

  logic [DIM_W-1:0] w_ext, h_ext, w_c, h_c;
  logic [FAC_W-1:0] wf_ext, hf_ext, wf_c, hf_c;
  logic             row_done_in, last_row, replay_row_done, final_copy, hf_one;
  logic             in_fire;
  logic [CPY_W-1:0] run_len_m1;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= CFG_DIM_W'(1);
      image_height  <= CFG_DIM_W'(1);
      width_factor  <= CFG_FAC_W'(1);
      height_factor <= CFG_FAC_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_reg_e'(cfg.index))
        REG_IMAGE_WIDTH:   image_width   <= cfg.data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg.data;
        REG_WIDTH_FACTOR:  width_factor  <= cfg.data[CFG_FAC_W-1:0];
        REG_HEIGHT_FACTOR: height_factor <= cfg.data[CFG_FAC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to their legal ranges
  always_comb begin
    w_ext  = DIM_W'(image_width);
    h_ext  = DIM_W'(image_height);
    wf_ext = FAC_W'(width_factor);
    hf_ext = FAC_W'(height_factor);
    w_c  = (w_ext == '0) ? DIM_W'(1) :
           (w_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w_ext;
    h_c  = (h_ext == '0) ? DIM_W'(1) :
           (h_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : h_ext;
    wf_c = (wf_ext == '0) ? FAC_W'(1) :
           (wf_ext > FAC_W'(MAX_FACTOR)) ? FAC_W'(MAX_FACTOR) : wf_ext;
    hf_c = (hf_ext == '0) ? FAC_W'(1) :
           (hf_ext > FAC_W'(MAX_FACTOR)) ? FAC_W'(MAX_FACTOR) : hf_ext;
  end

  assign run_len_m1      = CPY_W'(wf_c - FAC_W'(1));
  assign row_done_in     = (DIM_W'(in_column) + DIM_W'(1)) >= w_c;
  assign last_row        = (DIM_W'(in_row) + DIM_W'(1)) >= h_c;
  assign replay_row_done = (DIM_W'(replay_column) + DIM_W'(1)) >= w_c;
  assign final_copy      = (FAC_W'(replay_copy) + FAC_W'(1)) >= hf_c;
  assign hf_one          = (hf_c == FAC_W'(1));

  assign pix_in.ready = !job_valid || job_take;
  assign in_fire      = pix_in.valid && pix_in.ready;

  // Position bookkeeping and store access for the accepted beat
  always_comb begin
    in_column_next      = in_column;
    in_row_next         = in_row;
    replay_copy_next    = replay_copy;
    replay_column_next  = replay_column;
    replay_pending_next = replay_pending;
    new_job             = 1'b0;
    job_new             = '0;
    st_we               = 1'b0;
    st_re               = 1'b0;
    if (in_fire) begin
      if (pix_in.req_type == REQ_PIXEL) begin
        new_job = 1'b1;
        if (replay_pending) begin
          job_new.rejected = 1'b1;
        end else begin
          st_we             = 1'b1;
          job_new.pixel     = pix_in.pixel_in;
          job_new.row_end   = row_done_in;
          job_new.frame_end = row_done_in && last_row && hf_one;
          if (row_done_in) begin
            in_column_next = '0;
            if (!hf_one) begin
              replay_pending_next = 1'b1;
              replay_copy_next    = CPY_W'(1);
              replay_column_next  = '0;
            end else begin
              in_row_next = last_row ? '0 : in_row + COL_W'(1);
            end
          end else begin
            in_column_next = in_column + COL_W'(1);
          end
        end
      end else if (replay_pending) begin
        new_job            = 1'b1;
        st_re              = 1'b1;
        job_new.from_store = 1'b1;
        job_new.row_end    = replay_row_done;
        job_new.frame_end  = replay_row_done && final_copy && last_row;
        if (replay_row_done) begin
          replay_column_next = '0;
          if (final_copy) begin
            replay_pending_next = 1'b0;
            replay_copy_next    = '0;
            in_row_next         = last_row ? '0 : in_row + COL_W'(1);
          end else begin
            replay_copy_next = replay_copy + CPY_W'(1);
          end
        end else begin
          replay_column_next = replay_column + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column      <= '0;
      in_row         <= '0;
      replay_copy    <= '0;
      replay_column  <= '0;
      replay_pending <= 1'b0;
      job_valid      <= 1'b0;
    end else begin
      in_column      <= in_column_next;
      in_row         <= in_row_next;
      replay_copy    <= replay_copy_next;
      replay_column  <= replay_column_next;
      replay_pending <= replay_pending_next;
      if (new_job) begin
        job_valid <= 1'b1;
      end else if (job_take) begin
        job_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (new_job) begin
      job <= job_new;
    end
  end

  pru_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (in_column),
    .wdata (pix_in.pixel_in),
    .re    (st_re),
    .raddr (replay_column),
    .rdata (st_rdata)
  );

  pru_run_out #(
    .MAX_FACTOR(MAX_FACTOR)
  ) u_run_out (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .store_rdata (st_rdata),
    .run_len_m1  (run_len_m1),
    .job_take    (job_take),
    .out         (pix_out)
  );

  `ASSERT_IMPLIES(a_col_parked, clk, rst, replay_pending, in_column == '0,
                  "input column moved during replay")
  `ASSERT_IMPLIES(a_store_one_port, clk, rst, st_we, !st_re,
                  "line store written and read in the same cycle")
  `ASSERT_IMPLIES(a_reject_beat, clk, rst, pix_out.valid && pix_out.rejected,
                  pix_out.last_of_run && !pix_out.row_end && !pix_out.frame_end,
                  "rejected beat carries row or frame flags")
  `ASSERT_NEXT(a_frame_wrap, clk, rst, new_job && job_new.frame_end,
               in_row == '0 && !replay_pending && in_column == '0,
               "position not reset after frame end")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import pru_pkg::*;

  localparam int RANDOM_ITEMS = 460;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_of_run;
    logic             row_end;
    logic             frame_end;
    logic             rejected;
  } out_beat_t;

  class upscale_scoreboard;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic [CFG_FAC_W-1:0] wfac_reg;
    logic [CFG_FAC_W-1:0] hfac_reg;
    logic [PIX_W-1:0]     row_buf [DEF_MAX_WIDTH];
    int                   in_col;
    int                   in_row;
    int                   replay_col;
    logic [2:0]           copy_idx;
    bit                   replay_on;
    int                   store_hi;
    out_beat_t            beats_due [$];
    int                   errors;

    function new();
      width_reg = 1;
      height_reg = 1;
      wfac_reg = 1;
      hfac_reg = 1;
      in_col = 0;
      in_row = 0;
      replay_col = 0;
      copy_idx = 0;
      replay_on = 0;
      store_hi = 0;
      errors = 0;
    endfunction

    function int clamp(int v, int hi);
      return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DIM_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH:   width_reg = v;
        REG_IMAGE_HEIGHT:  height_reg = v;
        REG_WIDTH_FACTOR:  wfac_reg = v[CFG_FAC_W-1:0];
        REG_HEIGHT_FACTOR: hfac_reg = v[CFG_FAC_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_run(logic [PIX_W-1:0] pix, bit row_end, bit frame_end);
      int n;
      out_beat_t b;
      n = clamp(int'(wfac_reg), DEF_MAX_FACTOR);
      for (int k = 0; k < n; k++) begin
        b.pixel = pix;
        b.last_of_run = (k == n - 1);
        b.row_end = (k == n - 1) && row_end;
        b.frame_end = (k == n - 1) && frame_end;
        b.rejected = 1'b0;
        beats_due.push_back(b);
      end
    endfunction

    function void note_item(logic req, logic [PIX_W-1:0] pix);
      int w;
      int h;
      int hf;
      bit last_row;
      bit row_done;
      bit final_copy;
      out_beat_t b;
      w = clamp(int'(width_reg), DEF_MAX_WIDTH);
      h = clamp(int'(height_reg), DEF_MAX_WIDTH);
      hf = clamp(int'(hfac_reg), DEF_MAX_FACTOR);
      last_row = (in_row + 1 >= h);
      if (req == REQ_PIXEL) begin
        if (replay_on) begin
          b = '{pixel: '0, last_of_run: 1'b1, row_end: 1'b0, frame_end: 1'b0,
                rejected: 1'b1};
          beats_due.push_back(b);
          return;
        end
        row_buf[in_col] = pix;
        if (in_col + 1 > store_hi) store_hi = in_col + 1;
        row_done = (in_col + 1 >= w);
        push_run(pix, row_done, row_done && last_row && hf == 1);
        if (row_done) begin
          in_col = 0;
          if (hf > 1) begin
            replay_on = 1'b1;
            copy_idx = 3'd1;
            replay_col = 0;
          end else begin
            in_row = last_row ? 0 : in_row + 1;
          end
        end else begin
          in_col++;
        end
      end else begin
        if (!replay_on) return;
        row_done = (replay_col + 1 >= w);
        final_copy = (int'(copy_idx) + 1 >= hf);
        push_run(row_buf[replay_col], row_done, row_done && final_copy && last_row);
        if (row_done) begin
          replay_col = 0;
          if (final_copy) begin
            replay_on = 1'b0;
            copy_idx = 3'd0;
            in_row = last_row ? 0 : in_row + 1;
          end else begin
            copy_idx = copy_idx + 3'd1;
          end
        end else begin
          replay_col++;
        end
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (beats_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: pixel %h last %b row %b frame %b rej %b",
                   got.pixel, got.last_of_run, got.row_end, got.frame_end, got.rejected);
        return;
      end
      want = beats_due.pop_front();
      if (got.pixel !== want.pixel || got.last_of_run !== want.last_of_run ||
          got.row_end !== want.row_end || got.frame_end !== want.frame_end ||
          got.rejected !== want.rejected) begin
        errors++;
        if (errors <= 10)
          $display("beat mismatch: want pixel %h last %b row %b frame %b rej %b, got %h %b %b %b %b",
                   want.pixel, want.last_of_run, want.row_end, want.frame_end, want.rejected,
                   got.pixel, got.last_of_run, got.row_end, got.frame_end, got.rejected);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   in_idle_pct = 32;
  int   out_idle_pct = 32;
  int   cycle_count = 0;
  out_beat_t seen_beat;

  upscale_scoreboard board = new();

  pru_cfg_if cfg_bus ();
  pru_in_if  item_bus ();
  pru_out_if beat_bus ();

  pixel_replication_upscaler dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .pix_in  (item_bus),
    .pix_out (beat_bus)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && beat_bus.valid === 1'b1 && beat_bus.ready === 1'b1) begin
      seen_beat = '{pixel: beat_bus.pixel_out, last_of_run: beat_bus.last_of_run,
                    row_end: beat_bus.row_end, frame_end: beat_bus.frame_end,
                    rejected: beat_bus.rejected};
      board.check_beat(seen_beat);
    end
    beat_bus.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic send_item(logic req, logic [PIX_W-1:0] pix);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.req_type <= req;
    item_bus.pixel_in <= pix;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    board.note_item(req, pix);
  endtask

  // Hold the sender until every expected beat is back.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // A tick with nothing to replay leaves no beat behind, so keep clocking after the drain.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [CFG_DIM_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= v;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    board.write_reg(idx, v);
  endtask

  task automatic configure(logic [CFG_DIM_W-1:0] w, logic [CFG_DIM_W-1:0] h,
                           logic [CFG_DIM_W-1:0] wf, logic [CFG_DIM_W-1:0] hf);
    set_reg(REG_IMAGE_WIDTH, w);
    set_reg(REG_IMAGE_HEIGHT, h);
    set_reg(REG_WIDTH_FACTOR, wf);
    set_reg(REG_HEIGHT_FACTOR, hf);
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    int                   sent;
    int                   phase;
    int                   n;
    logic                 req;
    logic [PIX_W-1:0]     pix;
    logic [CFG_DIM_W-1:0] w;
    logic [CFG_DIM_W-1:0] h;
    logic [CFG_DIM_W-1:0] wf;
    logic [CFG_DIM_W-1:0] hf;

    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_IMAGE_WIDTH;
    cfg_bus.data <= '0;
    item_bus.valid <= 1'b0;
    item_bus.req_type <= REQ_PIXEL;
    item_bus.pixel_in <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: each pixel is a whole row and frame; a lone tick is ignored.
    send_item(REQ_PIXEL, 16'h0000);
    send_item(REQ_PIXEL, 16'hFFFF);
    send_item(REQ_TICK, 16'h1234);
    settle();

    // Two rows of three, widest runs, one replay each; one pixel bounces off the replay.
    configure(11'd3, 11'd2, 11'd8, 11'd2);
    for (int r = 0; r < 2; r++) begin
      send_item(REQ_PIXEL, 16'hAAAA);
      send_item(REQ_PIXEL, 16'h5555);
      send_item(REQ_PIXEL, 16'($urandom));
      if (r == 0) send_item(REQ_PIXEL, 16'hBEEF);
      repeat (3) send_item(REQ_TICK, 16'($urandom));
    end
    settle();

    // Zero sizes act as one, an oversized height factor acts as the maximum.
    configure(11'd0, 11'd0, 11'd0, 11'd15);
    send_item(REQ_PIXEL, 16'h8001);
    repeat (7) send_item(REQ_TICK, 16'($urandom));

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0: w = 11'd0;
        1: w = 11'd1024;
        2: w = 11'd2047;
        3: w = 11'($urandom_range(7, 40));
        default: w = 11'($urandom_range(1, 6));
      endcase
      // Keep a pending replay inside the part of the line store already written.
      if (board.replay_on && board.clamp(int'(w), DEF_MAX_WIDTH) > board.store_hi)
        w = 11'(board.store_hi);
      case ($urandom_range(0, 9))
        0: h = 11'd0;
        1: h = 11'd1024;
        2: h = 11'd2047;
        default: h = 11'($urandom_range(1, 4));
      endcase
      wf = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(9, 15)) : 11'($urandom_range(0, 8));
      hf = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(9, 15)) : 11'($urandom_range(0, 8));
      // Factor writes only use the low data bits; fill the rest with noise.
      wf[CFG_DIM_W-1:CFG_FAC_W] = 7'($urandom);
      hf[CFG_DIM_W-1:CFG_FAC_W] = 7'($urandom);
      configure(w, h, wf, hf);

      in_idle_pct = (phase == 3) ? 0 : 32;
      out_idle_pct = (phase == 3) ? 0 : 32;
      n = $urandom_range(25, 55);
      for (int k = 0; k < n; k++) begin
        if (phase == 1 && k == n / 2) drain_results();
        if (board.replay_on)
          req = ($urandom_range(0, 99) < 88) ? REQ_TICK : REQ_PIXEL;
        else
          req = ($urandom_range(0, 99) < 92) ? REQ_PIXEL : REQ_TICK;
        case ($urandom_range(0, 7))
          0: pix = '0;
          1: pix = '1;
          default: pix = 16'($urandom);
        endcase
        if (req == REQ_PIXEL || board.replay_on) sent++;
        send_item(req, pix);
      end
      phase++;
    end
    settle();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
